FILE: src/lckq_pkg.sv
// ----------------------------------------------------------------------------
// lckq_pkg
// Shared codes and controller/datapath interface types for the lock table.
// ----------------------------------------------------------------------------
package lckq_pkg;

    localparam logic [1:0] KIND_REPLY  = 2'd0;
    localparam logic [1:0] KIND_REVOKE = 2'd1;
    localparam logic [1:0] KIND_RETRY  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RETRY     = 2'd1;
    localparam logic [1:0] ST_NOT_OWNER = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic REQ_RELEASE = 1'b1;

    typedef struct packed {
        logic       accept;
        logic       scan_start;
        logic       scan_run;
        logic       claim;
        logic       set_held;
        logic       clr_held;
        logic       q_start;
        logic       q_run;
        logic       enqueue;
        logic       pop;
        logic       load_owner;
        logic       emit;
        logic [1:0] emit_kind;
        logic [1:0] emit_status;
        logic       emit_to_owner;
        logic       emit_last;
    } cmd_t;

    typedef struct packed {
        logic in_bad;
        logic req_rel;
        logic scan_done;
        logic hit;
        logic hit_held;
        logic free_found;
        logic owner_match;
        logic count_zero;
        logic count_full;
        logic q_done;
        logic waiting;
        logic pop_more;
        logic out_free;
    } sts_t;

endpackage

FILE: src/lckq_dpath.sv
// ----------------------------------------------------------------------------
// lckq_dpath
// Lock table, wait queue memory, search pipelines and result register.
// ----------------------------------------------------------------------------
module lckq_dpath #(
    parameter int LOCK_ENTRIES = 16,
    parameter int CLIENT_COUNT = 16,
    parameter int QUEUE_DEPTH  = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_req_type,
    input  logic [63:0]        s_lock_id,
    input  logic [3:0]         s_client_id,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic [1:0]         m_reply_status,
    output logic [3:0]         m_target_client,
    output logic [63:0]        m_target_lock,
    output logic               m_last,
    input  lckq_pkg::cmd_t     cmd,
    output lckq_pkg::sts_t     sts
);

    localparam int EW = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int AW = $clog2(LOCK_ENTRIES * QUEUE_DEPTH);

    // request
    logic        req_rel_reg;
    logic [63:0] req_lock_reg;
    logic [3:0]  req_client_reg;

    // table
    logic              valid_reg [LOCK_ENTRIES];
    logic              held_reg  [LOCK_ENTRIES];
    logic [63:0]       lock_mem  [LOCK_ENTRIES];
    logic [3:0]        owner_mem [LOCK_ENTRIES];
    logic [QW-1:0]     head_mem  [LOCK_ENTRIES];
    logic [CW-1:0]     count_mem [LOCK_ENTRIES];
    logic [3:0]        fifo_mem  [LOCK_ENTRIES * QUEUE_DEPTH];

    // table scan
    logic [EW:0]   scan_idx_reg;
    logic          cmp_vld_reg;
    logic [EW-1:0] cmp_idx_reg;
    logic [63:0]   lock_rd_reg;
    logic          hit_reg;
    logic [EW-1:0] hit_idx_reg;
    logic          free_vld_reg;
    logic [EW-1:0] free_idx_reg;
    logic          scan_issue;

    // entry read
    logic [3:0]    owner_rd_reg;
    logic [QW-1:0] head_rd_reg;
    logic [CW-1:0] count_rd_reg;
    logic [3:0]    tgt_owner_reg;

    // queue scan
    logic [CW-1:0] qi_reg;
    logic          qpend_reg;
    logic          waiting_reg;
    logic [3:0]    fifo_rd_reg;
    logic          q_issue;

    logic [EW-1:0] wr_idx;
    logic [AW-1:0] base_addr;
    logic [AW-1:0] fifo_raddr;
    logic [AW-1:0] fifo_waddr;

    // result register
    logic          m_valid_reg;
    logic [1:0]    m_kind_reg;
    logic [1:0]    m_status_reg;
    logic [3:0]    m_client_reg;
    logic [63:0]   m_lock_reg;
    logic          m_last_reg;

    function automatic logic [QW-1:0] wrap_slot(input logic [QW-1:0] head,
                                                input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(off);
        if (s >= SW'(QUEUE_DEPTH)) begin
            s = s - SW'(QUEUE_DEPTH);
        end
        return s[QW-1:0];
    endfunction

    assign scan_issue = cmd.scan_run && (scan_idx_reg < (EW+1)'(LOCK_ENTRIES));
    assign q_issue    = cmd.q_run && (qi_reg < count_rd_reg);
    assign wr_idx     = cmd.claim ? free_idx_reg : hit_idx_reg;
    assign base_addr  = AW'(hit_idx_reg) * AW'(QUEUE_DEPTH);
    assign fifo_raddr = base_addr + AW'(wrap_slot(head_rd_reg, qi_reg));
    assign fifo_waddr = base_addr + AW'(wrap_slot(head_rd_reg, count_rd_reg));

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_rel_reg    <= s_req_type;
            req_lock_reg   <= s_lock_id;
            req_client_reg <= s_client_id;
        end
    end

    // valid and held flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LOCK_ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
                held_reg[i]  <= 1'b0;
            end
        end else begin
            if (cmd.claim) begin
                valid_reg[free_idx_reg] <= 1'b1;
                held_reg[free_idx_reg]  <= 1'b1;
            end
            if (cmd.set_held) begin
                held_reg[hit_idx_reg] <= 1'b1;
            end
            if (cmd.clr_held) begin
                held_reg[hit_idx_reg] <= 1'b0;
            end
        end
    end

    // lock id memory
    always_ff @(posedge aclk) begin
        if (cmd.claim) begin
            lock_mem[free_idx_reg] <= req_lock_reg;
        end
        lock_rd_reg <= lock_mem[scan_idx_reg[EW-1:0]];
    end

    // per-entry owner / head / count memories
    always_ff @(posedge aclk) begin
        if (cmd.claim || cmd.set_held) begin
            owner_mem[wr_idx] <= req_client_reg;
        end else if (cmd.pop) begin
            owner_mem[wr_idx] <= fifo_rd_reg;
        end
        if (cmd.claim) begin
            head_mem[wr_idx] <= '0;
        end else if (cmd.pop) begin
            head_mem[wr_idx] <= wrap_slot(head_rd_reg, CW'(1));
        end
        if (cmd.claim) begin
            count_mem[wr_idx] <= '0;
        end else if (cmd.enqueue) begin
            count_mem[wr_idx] <= count_rd_reg + CW'(1);
        end else if (cmd.pop) begin
            count_mem[wr_idx] <= count_rd_reg - CW'(1);
        end
        owner_rd_reg <= owner_mem[hit_idx_reg];
        head_rd_reg  <= head_mem[hit_idx_reg];
        count_rd_reg <= count_mem[hit_idx_reg];
    end

    // wait queue memory
    always_ff @(posedge aclk) begin
        if (cmd.enqueue) begin
            fifo_mem[fifo_waddr] <= req_client_reg;
        end
        fifo_rd_reg <= fifo_mem[fifo_raddr];
    end

    // table scan: read one entry a cycle, compare it in the cycle after
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            free_vld_reg <= 1'b0;
        end else if (cmd.scan_start) begin
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            free_vld_reg <= 1'b0;
        end else if (cmd.scan_run) begin
            cmp_vld_reg <= scan_issue;
            if (scan_issue) begin
                scan_idx_reg <= scan_idx_reg + (EW+1)'(1);
            end
            if (cmp_vld_reg) begin
                if (valid_reg[cmp_idx_reg]) begin
                    if (!hit_reg && lock_rd_reg == req_lock_reg) begin
                        hit_reg <= 1'b1;
                    end
                end else if (!free_vld_reg) begin
                    free_vld_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_issue) begin
            cmp_idx_reg <= scan_idx_reg[EW-1:0];
        end
        if (cmd.scan_run && cmp_vld_reg) begin
            if (valid_reg[cmp_idx_reg]) begin
                if (!hit_reg && lock_rd_reg == req_lock_reg) begin
                    hit_idx_reg <= cmp_idx_reg;
                end
            end else if (!free_vld_reg) begin
                free_idx_reg <= cmp_idx_reg;
            end
        end
    end

    // wait queue scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qi_reg      <= '0;
            qpend_reg   <= 1'b0;
            waiting_reg <= 1'b0;
        end else if (cmd.q_start) begin
            qi_reg      <= '0;
            qpend_reg   <= 1'b0;
            waiting_reg <= 1'b0;
        end else if (cmd.q_run) begin
            qpend_reg <= q_issue;
            if (q_issue) begin
                qi_reg <= qi_reg + CW'(1);
            end
            if (qpend_reg && fifo_rd_reg == req_client_reg) begin
                waiting_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_owner) begin
            tgt_owner_reg <= owner_rd_reg;
        end else if (cmd.pop) begin
            tgt_owner_reg <= fifo_rd_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_kind_reg   <= cmd.emit_kind;
            m_status_reg <= cmd.emit_status;
            m_client_reg <= cmd.emit_to_owner ? tgt_owner_reg : req_client_reg;
            m_lock_reg   <= req_lock_reg;
            m_last_reg   <= cmd.emit_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_reply_status  = m_status_reg;
    assign m_target_client = m_client_reg;
    assign m_target_lock   = m_lock_reg;
    assign m_last          = m_last_reg;

    assign sts.in_bad      = (32'(s_client_id) >= 32'(CLIENT_COUNT));
    assign sts.req_rel     = (req_rel_reg == lckq_pkg::REQ_RELEASE);
    assign sts.scan_done   = hit_reg ||
                             (scan_idx_reg == (EW+1)'(LOCK_ENTRIES) && !cmp_vld_reg);
    assign sts.hit         = hit_reg;
    assign sts.hit_held    = held_reg[hit_idx_reg];
    assign sts.free_found  = free_vld_reg;
    assign sts.owner_match = (owner_rd_reg == req_client_reg);
    assign sts.count_zero  = (count_rd_reg == '0);
    assign sts.count_full  = (count_rd_reg == CW'(QUEUE_DEPTH));
    assign sts.q_done      = (qi_reg == count_rd_reg) && !qpend_reg;
    assign sts.waiting     = waiting_reg;
    assign sts.pop_more    = (count_rd_reg > CW'(1));
    assign sts.out_free    = !m_valid_reg || m_ready;

    a_claim_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.claim |-> free_vld_reg && !hit_reg)
        else $error("claim without a free entry");

    a_enq_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.enqueue |-> count_rd_reg < CW'(QUEUE_DEPTH) && !waiting_reg)
        else $error("enqueue into full queue or duplicate");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> count_rd_reg != '0 && held_reg[hit_idx_reg])
        else $error("pop of empty queue");

    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !m_valid_reg || m_ready)
        else $error("result register overwritten");

endmodule

FILE: src/lckq_ctrl.sv
// ----------------------------------------------------------------------------
// lckq_ctrl
// Request sequencer: search, decide, update and issue result transfers.
// ----------------------------------------------------------------------------
module lckq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  lckq_pkg::sts_t sts,
    output lckq_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN     = 4'd1;
    localparam logic [3:0] S_RDE      = 4'd2;
    localparam logic [3:0] S_EVAL     = 4'd3;
    localparam logic [3:0] S_QSCAN    = 4'd4;
    localparam logic [3:0] S_POPW     = 4'd5;
    localparam logic [3:0] S_POP      = 4'd6;
    localparam logic [3:0] S_E_RETRY  = 4'd7;
    localparam logic [3:0] S_E_REVOKE = 4'd8;
    localparam logic [3:0] S_E_REPLY  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [1:0] st_reg, st_next;
    logic       more_reg, more_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            st_reg    <= lckq_pkg::ST_OK;
            more_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            st_reg    <= st_next;
            more_reg  <= more_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        st_next    = st_reg;
        more_next  = more_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (sts.in_bad) begin
                        st_next    = lckq_pkg::ST_NOT_OWNER;
                        state_next = S_E_REPLY;
                    end else begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done) begin
                    if (sts.req_rel) begin
                        if (!sts.hit || !sts.hit_held) begin
                            st_next    = lckq_pkg::ST_OK;
                            state_next = S_E_REPLY;
                        end else begin
                            state_next = S_RDE;
                        end
                    end else if (!sts.hit) begin
                        if (sts.free_found) begin
                            cmd.claim = 1'b1;
                            st_next   = lckq_pkg::ST_OK;
                        end else begin
                            st_next = lckq_pkg::ST_FULL;
                        end
                        state_next = S_E_REPLY;
                    end else if (!sts.hit_held) begin
                        cmd.set_held = 1'b1;
                        st_next      = lckq_pkg::ST_OK;
                        state_next   = S_E_REPLY;
                    end else begin
                        state_next = S_RDE;
                    end
                end
            end
            S_RDE: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                cmd.load_owner = 1'b1;
                if (sts.req_rel) begin
                    if (!sts.owner_match) begin
                        st_next    = lckq_pkg::ST_NOT_OWNER;
                        state_next = S_E_REPLY;
                    end else if (sts.count_zero) begin
                        cmd.clr_held = 1'b1;
                        st_next      = lckq_pkg::ST_OK;
                        state_next   = S_E_REPLY;
                    end else begin
                        cmd.q_start = 1'b1;
                        state_next  = S_POPW;
                    end
                end else begin
                    cmd.q_start = 1'b1;
                    state_next  = S_QSCAN;
                end
            end
            S_QSCAN: begin
                cmd.q_run = 1'b1;
                if (sts.q_done) begin
                    if (!sts.waiting && sts.count_full) begin
                        st_next    = lckq_pkg::ST_FULL;
                        state_next = S_E_REPLY;
                    end else begin
                        cmd.enqueue = !sts.waiting;
                        st_next     = lckq_pkg::ST_RETRY;
                        state_next  = S_E_REVOKE;
                    end
                end
            end
            S_POPW: begin
                state_next = S_POP;
            end
            S_POP: begin
                cmd.pop    = 1'b1;
                more_next  = sts.pop_more;
                st_next    = lckq_pkg::ST_OK;
                state_next = S_E_RETRY;
            end
            S_E_RETRY: begin
                if (sts.out_free) begin
                    cmd.emit          = 1'b1;
                    cmd.emit_kind     = lckq_pkg::KIND_RETRY;
                    cmd.emit_status   = lckq_pkg::ST_OK;
                    cmd.emit_to_owner = 1'b1;
                    state_next        = more_reg ? S_E_REVOKE : S_E_REPLY;
                end
            end
            S_E_REVOKE: begin
                if (sts.out_free) begin
                    cmd.emit          = 1'b1;
                    cmd.emit_kind     = lckq_pkg::KIND_REVOKE;
                    cmd.emit_status   = lckq_pkg::ST_OK;
                    cmd.emit_to_owner = 1'b1;
                    state_next        = S_E_REPLY;
                end
            end
            S_E_REPLY: begin
                if (sts.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_kind   = lckq_pkg::KIND_REPLY;
                    cmd.emit_status = st_reg;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/lock_table_with_wait_queues.sv
// ----------------------------------------------------------------------------
// lock_table_with_wait_queues
// Lock server: grant, queue, revoke and hand-over of locks for many clients.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one acquire/release request per transfer (lock id,
//   client). m_* channel returns 1 to 3 result transfers per request: revoke
//   and retry messages first, then the reply to the requester with m_last=1.
//   Requests are handled one at a time. The lock table is searched one
//   entry per cycle (two-stage read/compare on the id memory), then an
//   acquire of a held lock walks the wait queue one slot per cycle.
//   Result transfers go out back to back while m_ready is high. The result
//   register is free to hold the final reply while the next request is
//   accepted; a stall on m_ready holds the sequencer at the next result.
//   Reset (aresetn low, synchronous) clears valid/held flags, the
//   sequencer and the result register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lock_table_with_wait_queues #(
    parameter int LOCK_ENTRIES = 16,
    parameter int CLIENT_COUNT = 16,
    parameter int QUEUE_DEPTH  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [63:0] s_lock_id,
    input  logic [3:0]  s_client_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [1:0]  m_reply_status,
    output logic [3:0]  m_target_client,
    output logic [63:0] m_target_lock,
    output logic        m_last
);

    lckq_pkg::cmd_t cmd;
    lckq_pkg::sts_t sts;

    // sequencer: owns all decisions, no payload
    lckq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // table, queues, search pipelines and result register
    lckq_dpath #(
        .LOCK_ENTRIES (LOCK_ENTRIES),
        .CLIENT_COUNT (CLIENT_COUNT),
        .QUEUE_DEPTH  (QUEUE_DEPTH)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_req_type      (s_req_type),
        .s_lock_id       (s_lock_id),
        .s_client_id     (s_client_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_reply_status  (m_reply_status),
        .m_target_client (m_target_client),
        .m_target_lock   (m_target_lock),
        .m_last          (m_last),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule

FILE: tb/sv/tb_lock_table_with_wait_queues.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lock_table_with_wait_queues
// Drives acquire/release requests with random gaps and result-side stalls,
// predicts grant/queue/revoke/retry results from a local lock table model
// and checks every result transfer in order.
// ----------------------------------------------------------------------------
module tb_lock_table_with_wait_queues;

    localparam int NLOCK      = 16;
    localparam int QDEPTH     = 16;
    localparam int PEND_DEPTH = 64;

    typedef struct {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [3:0]  client;
        logic [63:0] lock;
        logic        last;
    } lock_msg_t;

    // Lock table predictor plus expected-result ring.
    class lock_scoreboard;
        bit          ent_valid [NLOCK];
        logic [63:0] ent_id    [NLOCK];
        bit          ent_held  [NLOCK];
        logic [3:0]  ent_owner [NLOCK];
        logic [3:0]  waitq     [NLOCK][QDEPTH];
        int          head      [NLOCK];
        int          count     [NLOCK];
        lock_msg_t   pend_buf  [PEND_DEPTH];
        int          pend_rd;
        int          pend_wr;
        int          pend_cnt;
        int          errors;
        int          mismatches;

        function new();
            errors = 0;
            mismatches = 0;
            pend_rd = 0;
            pend_wr = 0;
            pend_cnt = 0;
            for (int e = 0; e < NLOCK; e++) begin
                ent_valid[e] = 0;
                ent_held[e] = 0;
                head[e] = 0;
                count[e] = 0;
            end
        endfunction

        function int outstanding();
            return pend_cnt;
        endfunction

        function void push(logic [1:0] k, logic [1:0] s, logic [3:0] c, logic [63:0] l);
            lock_msg_t m;
            m.kind = k;
            m.status = s;
            m.client = c;
            m.lock = l;
            m.last = 0;
            if (pend_cnt >= PEND_DEPTH) begin
                errors++;
                return;
            end
            pend_buf[pend_wr] = m;
            pend_wr = (pend_wr + 1) % PEND_DEPTH;
            pend_cnt++;
        endfunction

        function int lookup(logic [63:0] l);
            for (int e = 0; e < NLOCK; e++)
                if (ent_valid[e] && ent_id[e] == l) return e;
            return -1;
        endfunction

        // Note an accepted request and queue its expected results.
        function void note_request(logic rel, logic [63:0] l, logic [3:0] c);
            int  e;
            bit  waiting;
            e = lookup(l);
            if (rel != lckq_pkg::REQ_RELEASE) begin
                if (e < 0) begin
                    for (e = 0; e < NLOCK; e++)
                        if (!ent_valid[e]) break;
                    if (e >= NLOCK) begin
                        push(lckq_pkg::KIND_REPLY, lckq_pkg::ST_FULL, c, l);
                    end else begin
                        ent_valid[e] = 1;
                        ent_id[e] = l;
                        ent_held[e] = 1;
                        ent_owner[e] = c;
                        head[e] = 0;
                        count[e] = 0;
                        push(lckq_pkg::KIND_REPLY, lckq_pkg::ST_OK, c, l);
                    end
                end else if (!ent_held[e]) begin
                    ent_held[e] = 1;
                    ent_owner[e] = c;
                    push(lckq_pkg::KIND_REPLY, lckq_pkg::ST_OK, c, l);
                end else begin
                    waiting = 0;
                    for (int i = 0; i < count[e]; i++)
                        if (waitq[e][(head[e] + i) % QDEPTH] == c) waiting = 1;
                    if (!waiting && count[e] >= QDEPTH) begin
                        push(lckq_pkg::KIND_REPLY, lckq_pkg::ST_FULL, c, l);
                    end else begin
                        if (!waiting) begin
                            waitq[e][(head[e] + count[e]) % QDEPTH] = c;
                            count[e]++;
                        end
                        push(lckq_pkg::KIND_REVOKE, lckq_pkg::ST_OK, ent_owner[e], l);
                        push(lckq_pkg::KIND_REPLY, lckq_pkg::ST_RETRY, c, l);
                    end
                end
            end else begin
                if (e < 0 || !ent_held[e]) begin
                    push(lckq_pkg::KIND_REPLY, lckq_pkg::ST_OK, c, l);
                end else if (ent_owner[e] != c) begin
                    push(lckq_pkg::KIND_REPLY, lckq_pkg::ST_NOT_OWNER, c, l);
                end else if (count[e] == 0) begin
                    ent_held[e] = 0;
                    push(lckq_pkg::KIND_REPLY, lckq_pkg::ST_OK, c, l);
                end else begin
                    // hand-over to the head waiter
                    ent_owner[e] = waitq[e][head[e]];
                    head[e] = (head[e] + 1) % QDEPTH;
                    count[e]--;
                    push(lckq_pkg::KIND_RETRY, lckq_pkg::ST_OK, ent_owner[e], l);
                    if (count[e] > 0)
                        push(lckq_pkg::KIND_REVOKE, lckq_pkg::ST_OK, ent_owner[e], l);
                    push(lckq_pkg::KIND_REPLY, lckq_pkg::ST_OK, c, l);
                end
            end
            pend_buf[(pend_wr + PEND_DEPTH - 1) % PEND_DEPTH].last = 1;
        endfunction

        function void check_result(lock_msg_t got);
            lock_msg_t exp;
            if (pend_cnt == 0) begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result kind=%0d client=%0d lock=%h",
                             got.kind, got.client, got.lock);
                return;
            end
            exp = pend_buf[pend_rd];
            pend_rd = (pend_rd + 1) % PEND_DEPTH;
            pend_cnt--;
            if (got.kind !== exp.kind || got.status !== exp.status ||
                got.client !== exp.client || got.lock !== exp.lock ||
                got.last !== exp.last) begin
                errors++;
                if (mismatches++ < 10)
                    $display({"mismatch exp k%0d s%0d c%0d l%h last%0d",
                              " got k%0d s%0d c%0d l%h last%0d"},
                             exp.kind, exp.status, exp.client, exp.lock, exp.last,
                             got.kind, got.status, got.client, got.lock, got.last);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_req_type = 0;
    logic [63:0] s_lock_id = '0;
    logic [3:0]  s_client_id = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_kind;
    logic [1:0]  m_reply_status;
    logic [3:0]  m_target_client;
    logic [63:0] m_target_lock;
    logic        m_last;

    lock_scoreboard lock_sb = new();
    bit  calm = 0;       // no idling in the last part of the run
    bit  sink_on = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    lock_table_with_wait_queues i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_lock_id(s_lock_id), .s_client_id(s_client_id),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_reply_status(m_reply_status), .m_target_client(m_target_client),
        .m_target_lock(m_target_lock), .m_last(m_last)
    );

    // Result side: check each transfer, stall in random bursts.
    always @(posedge aclk) begin
        lock_msg_t got;
        if (aresetn && m_valid && m_ready) begin
            got.kind = m_kind;
            got.status = m_reply_status;
            got.client = m_target_client;
            got.lock = m_target_lock;
            got.last = m_last;
            lock_sb.check_result(got);
        end
    end

    initial begin
        int stall;
        @(posedge aclk iff sink_on);
        forever begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 17);
                m_ready <= 0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
        end
    end

    // Send one request; the transfer is noted in the predictor at acceptance.
    // s_valid stays high into the next request unless an idle gap is drawn.
    task automatic send_request(logic rel, logic [63:0] l, logic [3:0] c);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_req_type <= rel;
        s_lock_id <= l;
        s_client_id <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        lock_sb.note_request(rel, l, c);
    endtask

    logic [63:0] lock_pool [8];

    initial begin
        logic [63:0] l;
        logic [3:0]  c;
        int          k;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        sink_on = 1;
        @(posedge aclk);

        // Directed: extremes, queueing, duplicate waiter, hand-over, errors.
        send_request(0, 64'h0, 4'd0);
        send_request(0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        send_request(0, 64'h0, 4'd3);            // revoke to owner, queued
        send_request(0, 64'h0, 4'd3);            // already waiting
        send_request(0, 64'h0, 4'd5);
        send_request(0, 64'h0, 4'd0);            // owner acquires again
        send_request(1, 64'h0, 4'd7);            // not owner
        send_request(1, 64'h0, 4'd0);            // hand to 3, revoke 3
        send_request(1, 64'h0, 4'd3);            // hand to 5, revoke 5
        send_request(1, 64'h0, 4'd5);            // hand to 0, no revoke
        send_request(1, 64'h0, 4'd0);            // free
        send_request(1, 64'h0, 4'd0);            // release of free lock
        send_request(1, 64'h1234_5678_9ABC_DEF0, 4'd9); // unknown lock
        send_request(1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        // one owner and fifteen waiters on one lock
        for (int i = 0; i < 16; i++) send_request(0, 64'hA5A5, i[3:0]);
        send_request(0, 64'hA5A5, 4'd2);         // already waits
        // fill the table and overflow it
        for (int i = 0; i < 15; i++) send_request(0, 64'h5A00 + i, 4'd1);
        send_request(0, 64'hDEAD_BEEF_0000_0001, 4'd4); // table full

        // Random: reuse known ids; table is full so most hit existing locks.
        for (int i = 0; i < 8; i++) lock_pool[i] = (i < 4) ? 64'h5A00 + i : 64'h0;
        lock_pool[4] = 64'hA5A5;
        lock_pool[5] = 64'hFFFF_FFFF_FFFF_FFFF;
        for (int n = 0; n < 263; n++) begin
            if (n == 213) calm = 1;
            k = $urandom_range(0, 9);
            if (k == 0) l = {$urandom, $urandom};
            else l = lock_pool[$urandom_range(0, 7)];
            c = 4'($urandom_range(0, 15));
            send_request(1'($urandom_range(0, 1)), l, c);
        end
        s_valid <= 0;

        while (lock_sb.outstanding() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (lock_sb.errors == 0)
            $display("tb_lock_table_with_wait_queues: PASS");
        else
            $display("tb_lock_table_with_wait_queues: FAIL");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_lock_table_with_wait_queues: FAIL");
        $finish;
    end
endmodule
